@@ rtl/cds_pkg.sv @@
package cds_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned CNT_W   = 12;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned STAT_W  = 2;

  localparam logic [CNT_W-1:0]   MAX_DAY_COUNT = CNT_W'(4095);
  localparam logic [YEAR_W-1:0]  YEAR_MIN      = YEAR_W'(1);
  localparam logic [YEAR_W-1:0]  YEAR_MAX      = YEAR_W'(9999);
  localparam logic [YEAR_W-1:0]  YEAR_RST      = YEAR_W'(1990);
  localparam logic [MONTH_W-1:0] MONTH_JAN     = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB     = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC     = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_FIRST     = DAY_W'(1);
  localparam logic [DAY_W-1:0]   DAY_DEC_LAST  = DAY_W'(31);

  // commands
  localparam logic [CMD_W-1:0] CMD_LOAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_NEXT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PREV = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_SAT = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD = 2'd2;

  // floor(y/100) = (y * 5243) >> 19, exact for y < 16384
  localparam int unsigned RECIP_100  = 5243;
  localparam int unsigned RECIP_SH   = 19;
  localparam int unsigned PROD_W     = 27;
  localparam int unsigned CENT_W     = 8;
  localparam int unsigned BACK_W     = 15;

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [PROD_W-1:0] prod;
    logic [CENT_W-1:0] cent;
    logic [BACK_W-1:0] back;
    logic              div100;
    prod   = PROD_W'(y) * PROD_W'(RECIP_100);
    cent   = prod[RECIP_SH +: CENT_W];
    back   = BACK_W'(cent) * BACK_W'(100);
    div100 = (back == BACK_W'(y));
    return (y[1:0] == 2'b00) && (!div100 || (cent[1:0] == 2'b00));
  endfunction

  // days in month; zero for a month code outside 1..12
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
      4'd2:                                        len = leap ? DAY_W'(29) : DAY_W'(28);
      default:                                     len = '0;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/calendar_date_stepper_top.sv @@
// Gregorian date counter. Holds one date (reset 1990-01-01) and runs one
// command per input word: load, next day, previous day, add or subtract a
// day count (0..4095). Every command returns one output word with the date
// after the command and a status: 0 ok, 1 saturated at 0001-01-01 or
// 9999-12-31, 2 load rejected (date unchanged). Commands 5..7 echo the date.
// Timing: the block handles one word at a time and drops in_ready from
// acceptance until the result word is taken. A single shared month walker
// retires one month per cycle, and each crossing of a year boundary passes
// through S_LEAP to refresh the leap-year flag. Load runs S_LD_LEAP then
// S_LD_CHK; next/prev/add/sub run S_LEAP then the walk, before S_DONE.
module calendar_date_stepper_top
  import cds_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [YEAR_W-1:0]  in_load_year,
  input  logic [MONTH_W-1:0] in_load_month,
  input  logic [DAY_W-1:0]   in_load_day,
  input  logic [CNT_W-1:0]   in_day_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [YEAR_W-1:0]  out_cur_year,
  output logic [MONTH_W-1:0] out_cur_month,
  output logic [DAY_W-1:0]   out_cur_day,
  output logic [STAT_W-1:0]  out_status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_LEAP,
    S_LD_CHK,
    S_LEAP,
    S_ADD,
    S_SUB,
    S_DONE
  } state_t;

  state_t             state_r;
  logic [YEAR_W-1:0]  year_r;
  logic [MONTH_W-1:0] month_r;
  logic [DAY_W-1:0]   day_r;
  logic [STAT_W-1:0]  status_r;
  logic [CNT_W-1:0]   n_r;
  logic               add_r;     // direction of the walk
  logic               leap_r;    // leap flag of the year last run through the unit
  logic [YEAR_W-1:0]  ld_year_r;
  logic [MONTH_W-1:0] ld_month_r;
  logic [DAY_W-1:0]   ld_day_r;

  // shared leap unit: load year in S_LD_LEAP, else the held year
  logic [YEAR_W-1:0]  leap_src;
  logic               leap_calc;
  assign leap_src  = (state_r == S_LD_LEAP) ? ld_year_r : year_r;
  assign leap_calc = is_leap(leap_src);

  // month walker arithmetic
  logic [DAY_W-1:0]   cur_len;
  logic [DAY_W-1:0]   prev_len;
  logic [CNT_W:0]     day_sum;
  logic [DAY_W:0]     rest;       // days left in month including today
  logic [DAY_W-1:0]   ld_len;
  logic               ld_ok;
  logic [CNT_W-1:0]   cnt_clamp;

  assign cur_len  = month_len(month_r, leap_r);
  assign prev_len = month_len(month_r - MONTH_W'(1), leap_r);
  assign day_sum  = (CNT_W+1)'(day_r) + (CNT_W+1)'(n_r);
  assign rest     = (DAY_W+1)'(cur_len) - (DAY_W+1)'(day_r) + (DAY_W+1)'(1);
  assign ld_len   = month_len(ld_month_r, leap_r);
  assign ld_ok    = (ld_year_r >= YEAR_MIN) && (ld_year_r <= YEAR_MAX) &&
                    (ld_month_r >= MONTH_JAN) && (ld_month_r <= MONTH_DEC) &&
                    (ld_day_r != '0) && (ld_day_r <= ld_len);
  assign cnt_clamp = (in_day_count > MAX_DAY_COUNT) ? MAX_DAY_COUNT : in_day_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      year_r   <= YEAR_RST;
      month_r  <= MONTH_JAN;
      day_r    <= DAY_FIRST;
      status_r <= ST_OK;
      leap_r   <= 1'b0;
      add_r    <= 1'b0;
      n_r      <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ld_year_r  <= in_load_year;
            ld_month_r <= in_load_month;
            ld_day_r   <= in_load_day;
            status_r   <= ST_OK;
            case (in_cmd)
              CMD_LOAD: state_r <= S_LD_LEAP;
              CMD_NEXT: begin
                n_r     <= CNT_W'(1);
                add_r   <= 1'b1;
                state_r <= S_LEAP;
              end
              CMD_PREV: begin
                n_r     <= CNT_W'(1);
                add_r   <= 1'b0;
                state_r <= S_LEAP;
              end
              CMD_ADD: begin
                n_r     <= cnt_clamp;
                add_r   <= 1'b1;
                state_r <= S_LEAP;
              end
              CMD_SUB: begin
                n_r     <= cnt_clamp;
                add_r   <= 1'b0;
                state_r <= S_LEAP;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_LD_LEAP: begin
          leap_r  <= leap_calc;
          state_r <= S_LD_CHK;
        end
        S_LD_CHK: begin
          if (ld_ok) begin
            year_r  <= ld_year_r;
            month_r <= ld_month_r;
            day_r   <= ld_day_r;
          end else begin
            status_r <= ST_BAD;
          end
          state_r <= S_DONE;
        end
        S_LEAP: begin
          leap_r  <= leap_calc;
          state_r <= add_r ? S_ADD : S_SUB;
        end
        S_ADD: begin
          if (n_r == '0) begin
            state_r <= S_DONE;
          end else if (day_sum <= (CNT_W+1)'(cur_len)) begin
            day_r   <= DAY_W'(day_sum);
            state_r <= S_DONE;
          end else begin
            n_r <= n_r - CNT_W'(rest);
            if (month_r < MONTH_DEC) begin
              month_r <= month_r + MONTH_W'(1);
              day_r   <= DAY_FIRST;
            end else if (year_r >= YEAR_MAX) begin
              // clamp at the top of the range
              month_r  <= MONTH_DEC;
              day_r    <= DAY_DEC_LAST;
              status_r <= ST_SAT;
              state_r  <= S_DONE;
            end else begin
              year_r  <= year_r + YEAR_W'(1);
              month_r <= MONTH_JAN;
              day_r   <= DAY_FIRST;
              state_r <= S_LEAP;
            end
          end
        end
        S_SUB: begin
          if (n_r == '0) begin
            state_r <= S_DONE;
          end else if (n_r < CNT_W'(day_r)) begin
            day_r   <= day_r - DAY_W'(n_r);
            state_r <= S_DONE;
          end else begin
            n_r <= n_r - CNT_W'(day_r);
            if (month_r > MONTH_JAN) begin
              month_r <= month_r - MONTH_W'(1);
              day_r   <= prev_len;
            end else if (year_r <= YEAR_MIN) begin
              // clamp at the bottom of the range
              month_r  <= MONTH_JAN;
              day_r    <= DAY_FIRST;
              status_r <= ST_SAT;
              state_r  <= S_DONE;
            end else begin
              // December always has 31 days; refresh leap for the new year
              year_r  <= year_r - YEAR_W'(1);
              month_r <= MONTH_DEC;
              day_r   <= DAY_DEC_LAST;
              state_r <= S_LEAP;
            end
          end
        end
        S_DONE: begin
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = (state_r == S_DONE);
  assign out_cur_year  = year_r;
  assign out_cur_month = month_r;
  assign out_cur_day   = day_r;
  assign out_status    = status_r;

`ifndef NO_ASSERTIONS
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cur_month >= MONTH_JAN) && (out_cur_month <= MONTH_DEC) &&
                  (out_cur_day != '0))
    else $error("result word carries an invalid month or day");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result word is pending");

  a_sat_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_SAT) |->
      ((out_cur_year == YEAR_MAX && out_cur_month == MONTH_DEC &&
        out_cur_day == DAY_DEC_LAST) ||
       (out_cur_year == YEAR_MIN && out_cur_month == MONTH_JAN &&
        out_cur_day == DAY_FIRST)))
    else $error("saturated status without a range-end date");

  a_bad_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LD_CHK && !ld_ok) |=>
      (year_r == $past(year_r)) && (month_r == $past(month_r)) &&
      (day_r == $past(day_r)))
    else $error("rejected load changed the date");
`endif

endmodule

@@ test/cds_date_checker.sv @@
// Watches both channels of the date stepper, predicts every result word from
// the accepted input words, and compares in order.
module cds_date_checker
  import cds_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [YEAR_W-1:0]  in_load_year,
  input  logic [MONTH_W-1:0] in_load_month,
  input  logic [DAY_W-1:0]   in_load_day,
  input  logic [CNT_W-1:0]   in_day_count,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [YEAR_W-1:0]  out_cur_year,
  input  logic [MONTH_W-1:0] out_cur_month,
  input  logic [DAY_W-1:0]   out_cur_day,
  input  logic [STAT_W-1:0]  out_status,
  output int unsigned        fail_count,
  output int unsigned        pending_words
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [STAT_W-1:0]  status;
  } date_word_t;

  // predicted calendar
  logic [YEAR_W-1:0]  cal_year  = YEAR_RST;
  logic [MONTH_W-1:0] cal_month = MONTH_JAN;
  logic [DAY_W-1:0]   cal_day   = DAY_FIRST;

  date_word_t  expected_dates[$];
  int unsigned errors = 0;
  int unsigned owed   = 0;

  assign fail_count    = errors;
  assign pending_words = owed;

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in_month(input int y, input int m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // walk forward a month at a time, pin at the top end
  function automatic logic [STAT_W-1:0] advance_days(input int n);
    int len;
    while (n > 0) begin
      len = days_in_month(int'(cal_year), int'(cal_month));
      if (int'(cal_day) + n <= len) begin
        cal_day = DAY_W'(int'(cal_day) + n);
        return ST_OK;
      end
      n -= len - int'(cal_day) + 1;
      if (cal_month < MONTH_DEC) begin
        cal_month++;
        cal_day = DAY_FIRST;
      end else if (cal_year >= YEAR_MAX) begin
        cal_month = MONTH_DEC;
        cal_day   = DAY_DEC_LAST;
        return ST_SAT;
      end else begin
        cal_year++;
        cal_month = MONTH_JAN;
        cal_day   = DAY_FIRST;
      end
    end
    return ST_OK;
  endfunction

  // walk backward, pin at the bottom end
  function automatic logic [STAT_W-1:0] retreat_days(input int n);
    while (n > 0) begin
      if (n < int'(cal_day)) begin
        cal_day = DAY_W'(int'(cal_day) - n);
        return ST_OK;
      end
      n -= int'(cal_day);
      if (cal_month > MONTH_JAN) begin
        cal_month--;
      end else if (cal_year <= YEAR_MIN) begin
        cal_month = MONTH_JAN;
        cal_day   = DAY_FIRST;
        return ST_SAT;
      end else begin
        cal_year--;
        cal_month = MONTH_DEC;
      end
      cal_day = DAY_W'(days_in_month(int'(cal_year), int'(cal_month)));
    end
    return ST_OK;
  endfunction

  function automatic date_word_t step_calendar(input logic [CMD_W-1:0]   cmd,
                                               input logic [YEAR_W-1:0]  ly,
                                               input logic [MONTH_W-1:0] lm,
                                               input logic [DAY_W-1:0]   ld,
                                               input logic [CNT_W-1:0]   cnt);
    logic [STAT_W-1:0] st;
    int                count;
    date_word_t        res;
    st    = ST_OK;
    count = (cnt > MAX_DAY_COUNT) ? int'(MAX_DAY_COUNT) : int'(cnt);
    case (cmd)
      CMD_LOAD: begin
        if (ly < YEAR_MIN || ly > YEAR_MAX || lm < MONTH_JAN || lm > MONTH_DEC ||
            ld < DAY_FIRST || int'(ld) > days_in_month(int'(ly), int'(lm))) begin
          st = ST_BAD;
        end else begin
          cal_year  = ly;
          cal_month = lm;
          cal_day   = ld;
        end
      end
      CMD_NEXT: st = advance_days(1);
      CMD_PREV: st = retreat_days(1);
      CMD_ADD:  st = advance_days(count);
      CMD_SUB:  st = retreat_days(count);
      default:  st = ST_OK;
    endcase
    res.year   = cal_year;
    res.month  = cal_month;
    res.day    = cal_day;
    res.status = st;
    return res;
  endfunction

  always @(posedge clk) begin
    date_word_t want;
    if (!rst_n) begin
      cal_year  = YEAR_RST;
      cal_month = MONTH_JAN;
      cal_day   = DAY_FIRST;
      expected_dates.delete();
    end else begin
      // result side first, so a word taken at the same edge pairs correctly
      if (out_valid && out_ready) begin
        if (expected_dates.size() == 0) begin
          report_mismatch($sformatf("result word %0d-%0d-%0d st %0d with nothing expected",
                                    out_cur_year, out_cur_month, out_cur_day, out_status));
        end else begin
          want = expected_dates.pop_front();
          if (out_cur_year !== want.year)
            report_mismatch($sformatf("year %0d, expected %0d", out_cur_year, want.year));
          if (out_cur_month !== want.month)
            report_mismatch($sformatf("month %0d, expected %0d", out_cur_month, want.month));
          if (out_cur_day !== want.day)
            report_mismatch($sformatf("day %0d, expected %0d", out_cur_day, want.day));
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
        end
      end
      if (in_valid && in_ready)
        expected_dates.push_back(step_calendar(in_cmd, in_load_year, in_load_month,
                                               in_load_day, in_day_count));
    end
    owed = expected_dates.size();
  end

endmodule

@@ test/tb_calendar_date_stepper_top.sv @@
// Stimulus and verdict for the calendar date stepper. Checking lives in
// cds_date_checker, which sits beside the DUT on the same wires.
module tb_calendar_date_stepper_top
  import cds_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Watchdog budget for ~2000 words of worst-case walks plus stalls on both sides.
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned RANDOM_WORDS = 1950;
  // drain wait after the last result: longer than one full 4095-day walk
  localparam int unsigned DRAIN_CYCLES = 200;
  // receiver hold-off: starts once this many words went in, lasts this long
  localparam int unsigned HOLD_AT      = 500;
  localparam int unsigned HOLD_CYCLES  = 300;
  // window of words with no idling on either side
  localparam int unsigned CALM_FROM    = 900;
  localparam int unsigned CALM_TO      = 1150;
  // idle chance per cycle, percent
  localparam int unsigned IDLE_PCT     = 12;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CMD_W-1:0]   in_cmd = CMD_LOAD;
  logic [YEAR_W-1:0]  in_load_year = '0;
  logic [MONTH_W-1:0] in_load_month = '0;
  logic [DAY_W-1:0]   in_load_day = '0;
  logic [CNT_W-1:0]   in_day_count = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [YEAR_W-1:0]  out_cur_year;
  logic [MONTH_W-1:0] out_cur_month;
  logic [DAY_W-1:0]   out_cur_day;
  logic [STAT_W-1:0]  out_status;

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned words_sent = 0;

  wire calm = (words_sent >= CALM_FROM) && (words_sent < CALM_TO);

  calendar_date_stepper_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_load_year  (in_load_year),
    .in_load_month (in_load_month),
    .in_load_day   (in_load_day),
    .in_day_count  (in_day_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cur_year  (out_cur_year),
    .out_cur_month (out_cur_month),
    .out_cur_day   (out_cur_day),
    .out_status    (out_status)
  );

  cds_date_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_load_year  (in_load_year),
    .in_load_month (in_load_month),
    .in_load_day   (in_load_day),
    .in_day_count  (in_day_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cur_year  (out_cur_year),
    .out_cur_month (out_cur_month),
    .out_cur_day   (out_cur_day),
    .out_status    (out_status),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the DUT hangs.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Result sink. ready changes on the falling edge. One long hold-off lets
  // the DUT fill up with a finished word and drop in_ready while the sender
  // keeps its next word up.
  initial begin : result_sink
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && words_sent >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offer one word: random idle cycles first (valid low), then hold valid
  // and payload until the rising edge where in_ready is seen high. Back to
  // back words keep valid high and only swap the payload.
  task automatic offer_word(input logic [CMD_W-1:0]   cmd,
                            input logic [YEAR_W-1:0]  ly,
                            input logic [MONTH_W-1:0] lm,
                            input logic [DAY_W-1:0]   ld,
                            input logic [CNT_W-1:0]   cnt);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_load_year  <= ly;
    in_load_month <= lm;
    in_load_day   <= ld;
    in_day_count  <= cnt;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Day counts: mostly short walks to keep the run fast, some long ones,
  // a few at the full 12-bit range.
  function automatic logic [CNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70)
      return CNT_W'($urandom_range(60));
    else if (r < 90)
      return CNT_W'($urandom_range(400));
    return CNT_W'($urandom_range(int'(MAX_DAY_COUNT)));
  endfunction

  task automatic random_word();
    int unsigned        pick;
    logic [CMD_W-1:0]   cmd;
    logic [YEAR_W-1:0]  ly;
    logic [MONTH_W-1:0] lm;
    logic [DAY_W-1:0]   ld;
    logic [CNT_W-1:0]   cnt;
    pick = $urandom_range(99);
    // unused fields carry noise; a raw load uses them as they are
    ly   = YEAR_W'($urandom);
    lm   = MONTH_W'($urandom);
    ld   = DAY_W'($urandom);
    cnt  = CNT_W'($urandom);
    cmd  = CMD_LOAD;
    if (pick < 12) begin
      // well-formed load, biased toward both range ends and century years
      case ($urandom_range(4))
        0:       ly = YEAR_W'($urandom_range(3, 1));
        1:       ly = YEAR_W'($urandom_range(9999, 9990));
        2:       ly = YEAR_W'(100 * $urandom_range(99, 1));
        default: ly = YEAR_W'($urandom_range(int'(YEAR_MAX), int'(YEAR_MIN)));
      endcase
      lm = MONTH_W'($urandom_range(int'(MONTH_DEC), int'(MONTH_JAN)));
      // days 29..31 are valid or not depending on month and leap year
      ld = ($urandom_range(9) == 0) ? DAY_W'($urandom_range(31, 29))
                                    : DAY_W'($urandom_range(28, 1));
    end else if (pick < 16) begin
      cmd = CMD_LOAD;   // raw fields, mostly rejected
    end else if (pick < 31) begin
      cmd = CMD_NEXT;
    end else if (pick < 46) begin
      cmd = CMD_PREV;
    end else if (pick < 70) begin
      cmd = CMD_ADD;
      cnt = pick_count();
    end else if (pick < 94) begin
      cmd = CMD_SUB;
      cnt = pick_count();
    end else begin
      cmd = CMD_W'($urandom_range(int'(CMD_SUB) + 1, (1 << CMD_W) - 1));
    end
    offer_word(cmd, ly, lm, ld, cnt);
  endtask

  initial begin : stimulus
    int unsigned cmd_code;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // zero-length add right after reset shows the reset date
    offer_word(CMD_ADD, '0, '0, '0, '0);
    // leap rules: 400-year leap, century non-leap, plain years
    offer_word(CMD_LOAD, 14'd2000, 4'd2, 5'd29, '0);
    offer_word(CMD_LOAD, 14'd1900, 4'd2, 5'd29, '0);
    offer_word(CMD_LOAD, 14'd2023, 4'd2, 5'd29, '0);
    offer_word(CMD_LOAD, 14'd2024, 4'd2, 5'd29, '0);
    offer_word(CMD_NEXT, '0, '0, '0, '0);
    offer_word(CMD_PREV, '1, '1, '1, '1);
    // year rollover
    offer_word(CMD_LOAD, 14'd1999, MONTH_DEC, DAY_DEC_LAST, '0);
    offer_word(CMD_NEXT, '0, '0, '0, '0);
    // top end: step and full add saturate, zero subtract keeps the date
    offer_word(CMD_LOAD, YEAR_MAX, MONTH_DEC, DAY_DEC_LAST, '0);
    offer_word(CMD_NEXT, '0, '0, '0, '0);
    offer_word(CMD_ADD, '0, '0, '0, MAX_DAY_COUNT);
    offer_word(CMD_SUB, '0, '0, '0, '0);
    // bottom end
    offer_word(CMD_LOAD, YEAR_MIN, MONTH_JAN, DAY_FIRST, '1);
    offer_word(CMD_PREV, '0, '0, '0, '0);
    offer_word(CMD_SUB, '0, '0, '0, '1);
    // longest walks both ways
    offer_word(CMD_ADD, '0, '0, '0, '1);
    offer_word(CMD_SUB, '0, '0, '0, MAX_DAY_COUNT);
    // rejected loads: year zero, year all ones, month zero/all ones,
    // day zero, day 31 in a 30-day month
    offer_word(CMD_LOAD, '0, MONTH_JAN, DAY_FIRST, '0);
    offer_word(CMD_LOAD, '1, MONTH_JAN, DAY_FIRST, '0);
    offer_word(CMD_LOAD, 14'd2024, '0, DAY_FIRST, '0);
    offer_word(CMD_LOAD, 14'd2024, '1, DAY_FIRST, '0);
    offer_word(CMD_LOAD, 14'd2024, 4'd3, '0, '0);
    offer_word(CMD_LOAD, 14'd2024, 4'd4, 5'd31, '0);
    // unused command codes just echo the date
    for (cmd_code = int'(CMD_SUB) + 1; cmd_code < (1 << CMD_W); cmd_code++)
      offer_word(CMD_W'(cmd_code), '1, '1, '1, '1);

    // --- random ---
    repeat (RANDOM_WORDS) random_word();
    @(negedge clk);
    in_valid <= 1'b0;

    // drain: all results back, then some quiet cycles for stray words
    while (pending_words != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending_words == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cds_pkg.sv
rtl/calendar_date_stepper_top.sv
test/cds_date_checker.sv
test/tb_calendar_date_stepper_top.sv
